[rtl/lca_pkg.sv]
package lca_pkg;

   localparam int NODES     = 16384;
   localparam int MAX_DEPTH = 1024;
   localparam int ID_W      = $clog2(NODES);
   localparam int IDX_W     = $clog2(MAX_DEPTH);
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

   // command codes
   localparam logic [1:0] CMD_EDGE  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNKNOWN = 2'd1;
   localparam logic [1:0] STAT_NO_ROOT = 2'd2;
   localparam logic [1:0] STAT_DEPTH   = 2'd3;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [ID_W-1:0] node_a;
      logic [ID_W-1:0] node_b;
   } req_item_type;

   typedef struct packed {
      logic [ID_W-1:0] ancestor;
      logic [1:0]      status;
   } rsp_item_type;

   // node table access for one cycle
   typedef struct packed {
      logic [ID_W-1:0] wr_addr;
      logic [ID_W-1:0] rd_addr;
      logic            known_we;
      logic            known_val;
      logic            link_we;
      logic            link_val;
      logic [ID_W-1:0] parent;
   } tbl_cmd_type;

   // path store access for one cycle
   typedef struct packed {
      logic             we_a;
      logic             we_b;
      logic [IDX_W-1:0] wr_addr;
      logic [ID_W-1:0]  wr_data;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
   } path_cmd_type;

endpackage

[rtl/lowest_common_ancestor_unit.sv]
// edge item: marks a known, then b known with parent a; clear item: a table pass; unknown cmd: dropped
// query item: checks both nodes, walks a then b to the root, compares the paths from the root
//   down; the walk takes one step per cycle, and the last step waits on a full output
// one item at a time; a finished result waits in the output register while new items enter
// reset: synchronous, active high; a clearing pass over all NODES table entries then follows
//   with req_ready low (the same pass serves the clear command)
module lowest_common_ancestor_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lca_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lca_pkg::rsp_item_type rsp_item
);
   import lca_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_CHK_A,
      ST_CHK_B,
      ST_CHK_D,
      ST_WALK_A,
      ST_WALK_B,
      ST_CMP_GO,
      ST_CMP,
      ST_FIN
   } state_type;

   state_type        state_ff;
   logic [ID_W-1:0]  node_a_ff;
   logic [ID_W-1:0]  node_b_ff;
   logic [ID_W-1:0]  clr_ff;
   logic             known_a_ff;
   logic [ID_W-1:0]  cur_ff;
   logic [CNT_W-1:0] n_ff;
   logic [IDX_W-1:0] ia_ff;
   logic [IDX_W-1:0] ib_ff;
   logic             first_ff;
   logic [ID_W-1:0]  last_ff;
   logic [ID_W-1:0]  anc_ff;
   logic [1:0]       status_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   tbl_cmd_type      tbl_cmd;
   path_cmd_type     path_cmd;
   logic             known_q;
   logic             has_parent_q;
   logic [ID_W-1:0]  parent_q;
   logic [ID_W-1:0]  path_rd_a;
   logic [ID_W-1:0]  path_rd_b;
   logic             depth_full;
   logic             rsp_load;

   lca_node_table u_table (
      .clock        (clock),
      .tbl_cmd      (tbl_cmd),
      .known_q      (known_q),
      .has_parent_q (has_parent_q),
      .parent_q     (parent_q)
   );

   lca_path_store u_paths (
      .clock    (clock),
      .path_cmd (path_cmd),
      .rd_a     (path_rd_a),
      .rd_b     (path_rd_b)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   // chain already holds MAX_DEPTH nodes and still goes on
   assign depth_full = (n_ff == CNT_W'(MAX_DEPTH));
   // finished result moves into the output register once it is free
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // memory accesses driven by the sequencer state
   always_comb begin
      tbl_cmd  = '0;
      path_cmd = '0;
      path_cmd.wr_addr = n_ff[IDX_W-1:0];
      path_cmd.wr_data = cur_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // sweep known and has_parent back to zero
            tbl_cmd.wr_addr  = clr_ff;
            tbl_cmd.known_we = 1'b1;
            tbl_cmd.link_we  = 1'b1;
         end
         ST_EDGE_A: begin
            tbl_cmd.wr_addr   = node_a_ff;
            tbl_cmd.known_we  = 1'b1;
            tbl_cmd.known_val = 1'b1;
         end
         ST_EDGE_B: begin
            tbl_cmd.wr_addr   = node_b_ff;
            tbl_cmd.known_we  = 1'b1;
            tbl_cmd.known_val = 1'b1;
            tbl_cmd.link_we   = 1'b1;
            tbl_cmd.link_val  = 1'b1;
            tbl_cmd.parent    = node_a_ff;
         end
         ST_CHK_A: tbl_cmd.rd_addr = node_a_ff;
         ST_CHK_B: tbl_cmd.rd_addr = node_b_ff;
         // prefetch the first step of the walk for node a
         ST_CHK_D: tbl_cmd.rd_addr = node_a_ff;
         ST_WALK_A: begin
            // follow the parent straight from the read data, else start on node b
            tbl_cmd.rd_addr = has_parent_q ? parent_q : node_b_ff;
            path_cmd.we_a   = !depth_full;
         end
         ST_WALK_B: begin
            tbl_cmd.rd_addr = parent_q;
            path_cmd.we_b   = !depth_full;
         end
         ST_CMP_GO: begin
            path_cmd.rd_addr_a = ia_ff;
            path_cmd.rd_addr_b = ib_ff;
         end
         ST_CMP: begin
            // next pair one level below the root side; wraps harmlessly at the leaf
            path_cmd.rd_addr_a = ia_ff - 1'b1;
            path_cmd.rd_addr_b = ib_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ID_W'(NODES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  node_a_ff <= req_item.node_a;
                  node_b_ff <= req_item.node_b;
                  unique case (req_item.cmd)
                     CMD_EDGE:  state_ff <= ST_EDGE_A;
                     CMD_QUERY: state_ff <= ST_CHK_A;
                     CMD_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     default:   state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_EDGE_A: state_ff <= ST_EDGE_B;
            ST_EDGE_B: state_ff <= ST_IDLE;
            ST_CHK_A:  state_ff <= ST_CHK_B;
            ST_CHK_B: begin
               known_a_ff <= known_q;
               state_ff   <= ST_CHK_D;
            end
            ST_CHK_D: begin
               if (!known_a_ff || !known_q) begin
                  status_ff <= STAT_UNKNOWN;
                  anc_ff    <= '0;
                  state_ff  <= ST_FIN;
               end else begin
                  cur_ff   <= node_a_ff;
                  n_ff     <= '0;
                  state_ff <= ST_WALK_A;
               end
            end
            ST_WALK_A: begin
               if (depth_full) begin
                  status_ff <= STAT_DEPTH;
                  anc_ff    <= '0;
                  state_ff  <= ST_FIN;
               end else if (has_parent_q) begin
                  cur_ff <= parent_q;
                  n_ff   <= n_ff + 1'b1;
               end else begin
                  // root reached: remember its slot, then walk node b
                  ia_ff    <= n_ff[IDX_W-1:0];
                  cur_ff   <= node_b_ff;
                  n_ff     <= '0;
                  state_ff <= ST_WALK_B;
               end
            end
            ST_WALK_B: begin
               if (depth_full) begin
                  status_ff <= STAT_DEPTH;
                  anc_ff    <= '0;
                  state_ff  <= ST_FIN;
               end else if (has_parent_q) begin
                  cur_ff <= parent_q;
                  n_ff   <= n_ff + 1'b1;
               end else begin
                  ib_ff    <= n_ff[IDX_W-1:0];
                  first_ff <= 1'b1;
                  state_ff <= ST_CMP_GO;
               end
            end
            ST_CMP_GO: state_ff <= ST_CMP;
            ST_CMP: begin
               // compare both paths from the root downward, one pair a cycle
               if (path_rd_a != path_rd_b) begin
                  if (first_ff) begin
                     status_ff <= STAT_NO_ROOT;
                     anc_ff    <= '0;
                  end else begin
                     status_ff <= STAT_OK;
                     anc_ff    <= last_ff;
                  end
                  state_ff <= ST_FIN;
               end else if (ia_ff == '0 || ib_ff == '0) begin
                  // one path is exhausted: its leaf is the answer
                  status_ff <= STAT_OK;
                  anc_ff    <= path_rd_a;
                  state_ff  <= ST_FIN;
               end else begin
                  last_ff  <= path_rd_a;
                  first_ff <= 1'b0;
                  ia_ff    <= ia_ff - 1'b1;
                  ib_ff    <= ib_ff - 1'b1;
               end
            end
            ST_FIN: begin
               // hand the result to the output register once it is free
               if (rsp_load) begin
                  rsp_item_ff.ancestor <= anc_ff;
                  rsp_item_ff.status   <= status_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/lca_node_table.sv]
module lca_node_table (
   input  logic                     clock,
   input  lca_pkg::tbl_cmd_type     tbl_cmd,
   output logic                     known_q,
   output logic                     has_parent_q,
   output logic [lca_pkg::ID_W-1:0] parent_q
);
   import lca_pkg::*;

   logic            known_mem [NODES];
   logic            has_parent_mem [NODES];
   logic [ID_W-1:0] parent_mem [NODES];

   always_ff @(posedge clock) begin
      if (tbl_cmd.known_we) begin
         known_mem[tbl_cmd.wr_addr] <= tbl_cmd.known_val;
      end
      known_q <= known_mem[tbl_cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_cmd.link_we) begin
         has_parent_mem[tbl_cmd.wr_addr] <= tbl_cmd.link_val;
         parent_mem[tbl_cmd.wr_addr]     <= tbl_cmd.parent;
      end
      has_parent_q <= has_parent_mem[tbl_cmd.rd_addr];
      parent_q     <= parent_mem[tbl_cmd.rd_addr];
   end

endmodule

[rtl/lca_path_store.sv]
module lca_path_store (
   input  logic                     clock,
   input  lca_pkg::path_cmd_type    path_cmd,
   output logic [lca_pkg::ID_W-1:0] rd_a,
   output logic [lca_pkg::ID_W-1:0] rd_b
);
   import lca_pkg::*;

   logic [ID_W-1:0] path_a_mem [MAX_DEPTH];
   logic [ID_W-1:0] path_b_mem [MAX_DEPTH];

   always_ff @(posedge clock) begin
      if (path_cmd.we_a) begin
         path_a_mem[path_cmd.wr_addr] <= path_cmd.wr_data;
      end
      rd_a <= path_a_mem[path_cmd.rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (path_cmd.we_b) begin
         path_b_mem[path_cmd.wr_addr] <= path_cmd.wr_data;
      end
      rd_b <= path_b_mem[path_cmd.rd_addr_b];
   end

endmodule

[sim/lowest_common_ancestor_unit_test.sv]
`timescale 1ns / 1ps

module lowest_common_ancestor_unit_test;
   import lca_pkg::*;

   // cmd 3 has no meaning, the block drops it without a result
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // a clear item is a full table pass, a query walks both chains up to the depth limit
   localparam int QUERY_CYCLES = 3 * MAX_DEPTH + 16;
   localparam int IDLE_LIMIT   = 4 * (NODES + QUERY_CYCLES + 64);
   localparam int RANDOM_ITEMS = 255;
   localparam int LONG_HOLD    = 400;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   always #5 clock = ~clock;

   lowest_common_ancestor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // items waiting to be offered, answers waiting to come back
   req_item_type pending_items[$];
   rsp_item_type expected_answers[$];
   int           error_count  = 0;
   int           answers_seen = 0;

   // shadow of the node table, updated as each item is accepted
   logic [NODES-1:0] known_node      = '0;
   logic [NODES-1:0] has_parent_node = '0;
   logic [ID_W-1:0]  parent_tbl[NODES];

   // climb from a node to its root, leaf first; fails past the depth limit
   function automatic bit climb_chain(input logic [ID_W-1:0] start,
                                      output logic [ID_W-1:0] chain[$]);
      logic [ID_W-1:0] cur;
      bit              at_root;
      cur     = start;
      at_root = 1'b0;
      chain   = {};
      while (!at_root) begin
         if (chain.size() >= MAX_DEPTH) return 1'b0;
         chain = {chain, cur};
         if (!has_parent_node[cur]) at_root = 1'b1;
         else cur = parent_tbl[cur];
      end
      return 1'b1;
   endfunction

   // apply one accepted item to the shadow table; a query queues its answer
   task automatic predict_lca(input req_item_type it);
      logic [ID_W-1:0] chain_a[$];
      logic [ID_W-1:0] chain_b[$];
      rsp_item_type    ans;
      int              len_a;
      int              len_b;
      int              shared;
      ans = '0;
      case (it.cmd)
         CMD_EDGE: begin
            if (int'(it.node_a) < NODES && int'(it.node_b) < NODES) begin
               known_node[it.node_a]      = 1'b1;
               known_node[it.node_b]      = 1'b1;
               parent_tbl[it.node_b]      = it.node_a;
               has_parent_node[it.node_b] = 1'b1;
            end
         end
         CMD_CLEAR: begin
            known_node      = '0;
            has_parent_node = '0;
         end
         CMD_QUERY: begin
            // unknown ids win over the depth check
            if (int'(it.node_a) >= NODES || int'(it.node_b) >= NODES ||
                !known_node[it.node_a] || !known_node[it.node_b]) begin
               ans.status = STAT_UNKNOWN;
            end else if (!climb_chain(it.node_a, chain_a) ||
                         !climb_chain(it.node_b, chain_b)) begin
               ans.status = STAT_DEPTH;
            end else begin
               len_a = chain_a.size();
               len_b = chain_b.size();
               if (chain_a[len_a-1] != chain_b[len_b-1]) begin
                  ans.status = STAT_NO_ROOT;
               end else begin
                  // walk down from the shared root while the paths agree
                  shared = 0;
                  while (shared < len_a && shared < len_b &&
                         chain_a[len_a-1-shared] == chain_b[len_b-1-shared])
                     shared++;
                  ans.status   = STAT_OK;
                  ans.ancestor = chain_a[len_a-shared];
               end
            end
            expected_answers = {expected_answers, ans};
         end
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [1:0] cmd, input int a, input int b);
      req_item_type it;
      it.cmd    = cmd;
      it.node_a = a[ID_W-1:0];
      it.node_b = b[ID_W-1:0];
      pending_items = {pending_items, it};
   endtask

   // mostly any id, now and then one of the two extremes
   function automatic logic [ID_W-1:0] random_id();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(0, 1) ? '1 : '0;
      return ID_W'($urandom_range(0, NODES - 1));
   endfunction

   // sender: bursts of items with random gaps between them
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic         nxt_valid;
      req_item_type nxt_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
      end else begin
         nxt_valid = req_valid;
         nxt_item  = req_item;
         if (req_valid && req_ready) begin
            predict_lca(req_item);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               nxt_item  = pending_items.pop_front();
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  // some bursts run straight into the next one
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= nxt_valid;
         req_item  <= nxt_item;
      end
   end

   // receiver: checks each item, stalls in windows of changing density
   int  window_left    = 0;
   int  stall_mode     = 0;
   int  hold_left      = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_item_type exp_item;
      logic         nxt_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual ancestor %0d status %0d",
                        $time, rsp_item.ancestor, rsp_item.status);
               error_count++;
            end else begin
               exp_item = expected_answers.pop_front();
               if (rsp_item.ancestor !== exp_item.ancestor) begin
                  $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                           $time, exp_item.ancestor, rsp_item.ancestor);
                  error_count++;
               end
               if (rsp_item.status !== exp_item.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, exp_item.status, rsp_item.status);
                  error_count++;
               end
            end
         end
         // one long hold so the block backs up and stalls its input
         if (!long_hold_done && answers_seen >= 30) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else begin
            if (window_left <= 0) begin
               stall_mode  = $urandom_range(0, 2);
               window_left = $urandom_range(16, 96);
            end
            window_left--;
            case (stall_mode)
               0:       nxt_ready = 1'b1;
               1:       nxt_ready = 1'($urandom_range(0, 1));
               default: nxt_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= nxt_ready;
      end
   end

   // watchdog on cycles with no item moving on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [ID_W-1:0] gen_nodes[$];
      logic [ID_W-1:0] node_x;
      logic [ID_W-1:0] node_y;
      int              made;
      int              clears_left;
      int              roll;
      int              pick;

      // directed part
      add_item(CMD_QUERY, 3, 4);                  // empty table, unknown
      add_item(CMD_UNUSED, NODES - 1, NODES - 1); // dropped
      add_item(CMD_EDGE, 0, NODES - 1);
      add_item(CMD_EDGE, 0, 100);
      add_item(CMD_EDGE, 100, 200);
      add_item(CMD_EDGE, NODES - 1, 300);
      add_item(CMD_QUERY, 200, 300);              // meet at root
      add_item(CMD_QUERY, 200, 100);              // one is ancestor of other
      add_item(CMD_QUERY, NODES - 1, NODES - 1);  // node with itself
      add_item(CMD_QUERY, 0, 0);                  // lone root with itself
      add_item(CMD_QUERY, 200, 9999);             // second node unknown
      add_item(CMD_EDGE, 500, 501);               // separate tree
      add_item(CMD_QUERY, 501, 200);              // different roots
      add_item(CMD_EDGE, 501, 500);               // closes a loop
      add_item(CMD_QUERY, 500, 0);                // loop on first chain
      add_item(CMD_QUERY, 0, 500);                // loop on second chain
      add_item(CMD_QUERY, 500, 9999);             // unknown beats the loop
      add_item(CMD_EDGE, NODES - 1, 100);         // overwrite a parent
      add_item(CMD_QUERY, 200, 300);
      add_item(CMD_CLEAR, 0, 0);
      add_item(CMD_QUERY, 200, 300);              // gone after clear
      add_item(CMD_EDGE, 7, 8);
      add_item(CMD_QUERY, 8, 7);

      // random part: growing trees, queries over them, some noise
      made        = 0;
      clears_left = 5;
      while (made < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            add_item(CMD_UNUSED, int'(random_id()), int'(random_id()));
         end else if (roll < 8 && clears_left > 0) begin
            add_item(CMD_CLEAR, int'(random_id()), int'(random_id()));
            gen_nodes.delete();
            clears_left--;
            made++;
         end else if (gen_nodes.size() < 2 || roll < 45) begin
            // new child under a fresh root, the newest node or any node
            node_y = random_id();
            pick   = $urandom_range(0, 9);
            if (gen_nodes.size() == 0 || pick < 2) begin
               node_x = random_id();
               gen_nodes = {gen_nodes, node_x};
            end else if (pick < 6) begin
               node_x = gen_nodes[$];
            end else begin
               node_x = gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
            end
            gen_nodes = {gen_nodes, node_y};
            add_item(CMD_EDGE, int'(node_x), int'(node_y));
            made++;
         end else if (roll < 51) begin
            // rewire a known node, may well close a loop
            node_x = gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
            node_y = gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
            add_item(CMD_EDGE, int'(node_x), int'(node_y));
            made++;
         end else begin
            node_x = ($urandom_range(0, 9) == 0) ? random_id() :
                     gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
            node_y = ($urandom_range(0, 9) == 0) ? random_id() :
                     gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
            if ($urandom_range(0, 9) == 0) node_y = node_x;
            add_item(CMD_QUERY, int'(node_x), int'(node_y));
            made++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain, then leave room for any stray result
      while (pending_items.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (QUERY_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
